// ===== src/scgr_pkg.sv =====
// scgr_pkg: shared types and the microcode program of the stereo clip, gain and resonator block
// control word layout, register index codes, program table function
// no dependencies
`default_nettype none

package scgr_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_CLIP_LEVEL   = 3'd0;
    localparam logic [2:0] CFG_AMP_GAIN     = 3'd1;
    localparam logic [2:0] CFG_RESON_ENABLE = 3'd2;
    localparam logic [2:0] CFG_COEF_A       = 3'd3;
    localparam logic [2:0] CFG_COEF_B1      = 3'd4;
    localparam logic [2:0] CFG_COEF_B2      = 3'd5;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int PC_BITS        = 4;

    // multiplier operand pair
    typedef enum logic [1:0] {
        MUL_GAIN,   // clipped sample * amp_gain
        MUL_A,      // gained sample * coef_a
        MUL_B1,     // y1 * coef_b1
        MUL_B2      // y2 * coef_b2
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        t_mul_sel           mul_sel;
        t_acc_op            acc_op;
        logic               g_load;   // take gained sample from the product
        logic               fin;      // produce the channel result
        logic               ch;       // 0 left, 1 right
        logic               jmp_byp;  // jump to target when the resonator is off
        logic               last;     // final step of the frame
        logic [PC_BITS-1:0] target;
    } t_ctrl;

    function automatic t_ctrl mk_step(logic ch, t_mul_sel mul, t_acc_op acc, logic gl,
                                      logic fin, logic jmp, logic last,
                                      logic [PC_BITS-1:0] tgt);
        t_ctrl w;
        w.mul_sel = mul;
        w.acc_op  = acc;
        w.g_load  = gl;
        w.fin     = fin;
        w.ch      = ch;
        w.jmp_byp = jmp;
        w.last    = last;
        w.target  = tgt;
        return w;
    endfunction

    // program: seven steps per channel, left then right
    function automatic t_ctrl ucode(logic [PC_BITS-1:0] pc);
        t_ctrl w;
        unique case (pc)
            4'd0:    w = mk_step(1'b0, MUL_GAIN, ACC_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            4'd1:    w = mk_step(1'b0, MUL_GAIN, ACC_HOLD, 1'b1, 1'b0, 1'b1, 1'b0, 4'd6);
            4'd2:    w = mk_step(1'b0, MUL_A,    ACC_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            4'd3:    w = mk_step(1'b0, MUL_B1,   ACC_LOAD, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            4'd4:    w = mk_step(1'b0, MUL_B2,   ACC_ADD,  1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            4'd5:    w = mk_step(1'b0, MUL_GAIN, ACC_ADD,  1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            4'd6:    w = mk_step(1'b0, MUL_GAIN, ACC_HOLD, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0);
            4'd7:    w = mk_step(1'b1, MUL_GAIN, ACC_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            4'd8:    w = mk_step(1'b1, MUL_GAIN, ACC_HOLD, 1'b1, 1'b0, 1'b1, 1'b0, 4'd13);
            4'd9:    w = mk_step(1'b1, MUL_A,    ACC_HOLD, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            4'd10:   w = mk_step(1'b1, MUL_B1,   ACC_LOAD, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            4'd11:   w = mk_step(1'b1, MUL_B2,   ACC_ADD,  1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            4'd12:   w = mk_step(1'b1, MUL_GAIN, ACC_ADD,  1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
            4'd13:   w = mk_step(1'b1, MUL_GAIN, ACC_HOLD, 1'b0, 1'b1, 1'b0, 1'b1, 4'd0);
            default: w = mk_step(1'b1, MUL_GAIN, ACC_HOLD, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/scgr_seq.sv =====
// scgr_seq: step counter and program sequencer
// reads the control word from the program table in scgr_pkg
// depends on scgr_pkg
`default_nettype none

module scgr_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,     // frame request taken
    input  wire logic          i_hold,      // output register still full
    input  wire logic          i_reson_en,
    output scgr_pkg::t_ctrl    o_ctrl,
    output logic               o_step_en,
    output logic               o_busy
);
    import scgr_pkg::*;

    logic [PC_BITS-1:0] r_pc, n_pc;
    logic               r_busy, n_busy;
    t_ctrl              ctrl;
    logic               step_en;

    assign ctrl    = ucode(r_pc);
    // the final step waits while the previous result has not left
    assign step_en = r_busy && !(ctrl.last && i_hold);

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_start) begin
            n_pc   = '0;
            n_busy = 1'b1;
        end else if (step_en) begin
            if (ctrl.last) begin
                n_busy = 1'b0;
            end else if (ctrl.jmp_byp && !i_reson_en) begin
                n_pc = ctrl.target;
            end else begin
                n_pc = r_pc + PC_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_ctrl    = ctrl;
    assign o_step_en = step_en;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

// ===== src/scgr_dp.sv =====
// scgr_dp: datapath with clip, one shared multiplier, accumulator and resonator history
// driven by the control word from scgr_seq
// depends on scgr_pkg
`default_nettype none

module scgr_dp #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right,
    input  wire scgr_pkg::t_ctrl               i_ctrl,
    input  wire logic                          i_step_en,
    input  wire logic [14:0]                   i_clip_level,
    input  wire logic [15:0]                   i_amp_gain,
    input  wire logic                          i_reson_en,
    input  wire logic signed [15:0]            i_coef_a,
    input  wire logic signed [15:0]            i_coef_b1,
    input  wire logic signed [15:0]            i_coef_b2,
    output logic signed [SAMPLE_BITS-1:0]      o_res_left,
    output logic signed [SAMPLE_BITS-1:0]      o_y_fin
);
    import scgr_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int F  = COEF_FRAC_BITS;
    localparam int CW = ((SB > 16) ? SB : 16) + 1;
    localparam int PW = SB + 17;
    localparam int GW = PW - GAIN_FRAC_BITS;
    localparam int AW = (F > 18) ? (SB + F + 1) : (SB + 19);
    localparam int YW = AW - F;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = ~S_MAX;
    localparam logic signed [GW-1:0] G_MAX = GW'(S_MAX);
    localparam logic signed [GW-1:0] G_MIN = ~G_MAX;
    localparam logic signed [YW-1:0] Y_MAX = YW'(S_MAX);
    localparam logic signed [YW-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [AW-1:0] A_HALF = AW'(1) << (F - 1);

    logic signed [SB-1:0] r_x_l, r_x_r;
    logic signed [SB-1:0] r_y1_l, r_y2_l, r_y1_r, r_y2_r;
    logic signed [SB-1:0] r_g, r_res_l;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;

    logic signed [SB-1:0] x_sel, y1_sel, y2_sel, x_clip;
    logic signed [CW-1:0] x_ext, lim_pos, lim_neg, clip_ext;
    logic signed [SB-1:0] mul_a;
    logic signed [16:0]   mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [GW-1:0] g_sh;
    logic signed [SB-1:0] g_sat;
    logic signed [AW-1:0] prod_ext, acc_rnd;
    logic signed [YW-1:0] y_sh;
    logic signed [SB-1:0] y_sat, y_fin;

    assign x_sel  = i_ctrl.ch ? r_x_r  : r_x_l;
    assign y1_sel = i_ctrl.ch ? r_y1_r : r_y1_l;
    assign y2_sel = i_ctrl.ch ? r_y2_r : r_y2_l;

    // symmetric clip, compared wide so a level beyond the sample range passes all
    assign x_ext    = CW'(x_sel);
    assign lim_pos  = signed'(CW'(i_clip_level));
    assign lim_neg  = -lim_pos;
    assign clip_ext = (x_ext > lim_pos) ? lim_pos : ((x_ext < lim_neg) ? lim_neg : x_ext);
    assign x_clip   = clip_ext[SB-1:0];

    always_comb begin
        unique case (i_ctrl.mul_sel)
            MUL_GAIN: begin
                mul_a = x_clip;
                mul_b = signed'({1'b0, i_amp_gain});
            end
            MUL_A: begin
                mul_a = r_g;
                mul_b = 17'(i_coef_a);
            end
            MUL_B1: begin
                mul_a = y1_sel;
                mul_b = 17'(i_coef_b1);
            end
            MUL_B2: begin
                mul_a = y2_sel;
                mul_b = 17'(i_coef_b2);
            end
            default: begin
                mul_a = x_clip;
                mul_b = signed'({1'b0, i_amp_gain});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // gain stage: floor shift then saturate
    assign g_sh  = r_prod[PW-1:GAIN_FRAC_BITS];
    assign g_sat = (g_sh > G_MAX) ? S_MAX : ((g_sh < G_MIN) ? S_MIN : g_sh[SB-1:0]);

    // filter result: round half up, then saturate
    assign prod_ext = AW'(r_prod);
    assign acc_rnd  = r_acc + A_HALF;
    assign y_sh     = acc_rnd[AW-1:F];
    assign y_sat    = (y_sh > Y_MAX) ? S_MAX : ((y_sh < Y_MIN) ? S_MIN : y_sh[SB-1:0]);
    assign y_fin    = i_reson_en ? y_sat : r_g;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x_l <= i_left;
            r_x_r <= i_right;
        end
        if (i_step_en) begin
            r_prod <= mul_p;
            if (i_ctrl.g_load) begin
                r_g <= g_sat;
            end
            unique case (i_ctrl.acc_op)
                ACC_LOAD: r_acc <= prod_ext;
                ACC_ADD:  r_acc <= r_acc + prod_ext;
                default:  r_acc <= r_acc;
            endcase
            if (i_ctrl.fin && !i_ctrl.ch) begin
                r_res_l <= y_fin;
            end
        end
    end

    // resonator history, held in bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y1_l <= '0;
            r_y2_l <= '0;
            r_y1_r <= '0;
            r_y2_r <= '0;
        end else if (i_step_en && i_ctrl.fin && i_reson_en) begin
            if (i_ctrl.ch) begin
                r_y2_r <= r_y1_r;
                r_y1_r <= y_sat;
            end else begin
                r_y2_l <= r_y1_l;
                r_y1_l <= y_sat;
            end
        end
    end

    assign o_res_left = r_res_l;
    assign o_y_fin    = y_fin;

endmodule

`default_nettype wire

// ===== src/stereo_clip_gain_resonator.sv =====
// stereo_clip_gain_resonator: stereo clip, Q8.8 gain and two-pole resonator
// holds the configuration registers and the output register
// depends on scgr_pkg, scgr_seq, scgr_dp
//
// channel   direction  handshake                       payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: left_in, right_in
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: left_out, right_out
// cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// one frame at a time through a single shared multiplier stepped by a microcode program:
// 14 steps with the resonator on, 6 in bypass; a new frame is taken only once the sequencer
// is idle again, after the last step of the previous frame
// a finished frame waits in the output register; the next frame runs meanwhile and its
// last step holds only if that register is still full
// synchronous active-low reset clears history, control, output valid and config to defaults
`default_nettype none

module stereo_clip_gain_resonator #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // [SAMPLE_BITS-1:0] left_in, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_in, zero pad above
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // [SAMPLE_BITS-1:0] left_out, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_out, zero pad above
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]            m_axis_tdata,
    input  wire logic                                     i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  wire logic [2:0]                               i_cfg_index,
    input  wire logic [15:0]                              i_cfg_data
);
    import scgr_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int DW = ((2*SAMPLE_BITS+7)/8)*8;

    logic [14:0]          r_clip_level;
    logic [15:0]          r_amp_gain;
    logic                 r_reson_en;
    logic signed [15:0]   r_coef_a, r_coef_b1, r_coef_b2;

    logic                 r_m_valid;
    logic signed [SB-1:0] r_out_l, r_out_r;

    t_ctrl                ctrl;
    logic                 step_en, busy, start, out_load;
    logic signed [SB-1:0] res_l, y_fin;

    assign s_axis_tready = !busy;
    assign start         = s_axis_tvalid && !busy;
    assign o_cfg_ready   = 1'b1;
    assign out_load      = step_en && ctrl.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_level <= 15'd32767;
            r_amp_gain   <= 16'd256;
            r_reson_en   <= 1'b0;
            r_coef_a     <= 16'sd16384;
            r_coef_b1    <= '0;
            r_coef_b2    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLIP_LEVEL:   r_clip_level <= i_cfg_data[14:0];
                CFG_AMP_GAIN:     r_amp_gain   <= i_cfg_data;
                CFG_RESON_ENABLE: r_reson_en   <= i_cfg_data[0];
                CFG_COEF_A:       r_coef_a     <= signed'(i_cfg_data);
                CFG_COEF_B1:      r_coef_b1    <= signed'(i_cfg_data);
                CFG_COEF_B2:      r_coef_b2    <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_l <= res_l;
            r_out_r <= y_fin;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = DW'({r_out_r, r_out_l});

    scgr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_hold     (r_m_valid && !m_axis_tready),
        .i_reson_en (r_reson_en),
        .o_ctrl     (ctrl),
        .o_step_en  (step_en),
        .o_busy     (busy)
    );

    scgr_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (start),
        .i_left       (signed'(s_axis_tdata[SB-1:0])),
        .i_right      (signed'(s_axis_tdata[2*SB-1:SB])),
        .i_ctrl       (ctrl),
        .i_step_en    (step_en),
        .i_clip_level (r_clip_level),
        .i_amp_gain   (r_amp_gain),
        .i_reson_en   (r_reson_en),
        .i_coef_a     (r_coef_a),
        .i_coef_b1    (r_coef_b1),
        .i_coef_b2    (r_coef_b2),
        .o_res_left   (res_l),
        .o_y_fin      (y_fin)
    );

endmodule

`default_nettype wire
